// ===== rtl/rgbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbq_pkg : RGB-IR quad IR subtraction types and constants
// Payload structures, register indexes and the per-colour correction
// arithmetic shared by the IR subtraction core.
// ----------------------------------------------------------------------------
package rgbq_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int OUT_BITS      = 10;
   localparam int GAIN_BITS     = 10;
   localparam int GEOM_BITS     = 12;
   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_IDX_BITS  = 3;
   localparam int PAIR_BITS     = 2 * SAMPLE_BITS;

   localparam logic [CSR_IDX_BITS-1:0] REG_LINE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_ROWS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUT_MODE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_B     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_G     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_R     = 3'd5;

   localparam logic MODE_8BIT  = 1'b0;
   localparam logic MODE_10BIT = 1'b1;

   localparam logic [GEOM_BITS-1:0] LINE_WIDTH_RESET = 12'd2048;
   localparam logic [GEOM_BITS-1:0] FRAME_ROWS_RESET = 12'd2048;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET       = 10'd256;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_sample;
      logic                   frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] blue_out;
      logic [OUT_BITS-1:0] green_out;
      logic [OUT_BITS-1:0] red_out;
      logic [OUT_BITS-1:0] ir_out;
      logic [OUT_BITS-1:0] quad_col;
      logic [OUT_BITS-1:0] quad_row;
      logic                frame_done;
   } rsp_payload_type;

   // IR value used in the subtraction: clipped to 255 in 8-bit mode
   function automatic logic [SAMPLE_BITS-1:0] ir_for_subtract(
      input logic [SAMPLE_BITS-1:0] ir,
      input logic                   mode
   );
      logic [SAMPLE_BITS-1:0] res;
      res = ir;
      if (mode == MODE_8BIT && ir > 10'd255) begin
         res = 10'd255;
      end
      return res;
   endfunction

   // IR value as reported
   function automatic logic [OUT_BITS-1:0] ir_report(
      input logic [SAMPLE_BITS-1:0] ir,
      input logic                   mode
   );
      logic [OUT_BITS-1:0] res;
      if (mode == MODE_8BIT) begin
         res = ir_for_subtract(ir, mode);
      end else if (ir > 10'd511) begin
         res = 10'd1023;
      end else begin
         res = {ir[8:0], 1'b0};
      end
      return res;
   endfunction

   // colour minus floor(gain * ir / 256), doubled in 10-bit mode, clipped per mode
   function automatic logic [OUT_BITS-1:0] correct_colour(
      input logic [SAMPLE_BITS-1:0] colour,
      input logic [GAIN_BITS-1:0]   gain,
      input logic [SAMPLE_BITS-1:0] ir,
      input logic                   mode
   );
      logic [19:0]        prod;
      logic signed [13:0] diff;
      logic signed [14:0] dbl;
      logic [OUT_BITS-1:0] res;
      prod = gain * ir;
      diff = $signed({4'b0, colour}) - $signed({2'b0, prod[19:8]});
      dbl  = {diff, 1'b0};
      if (mode == MODE_8BIT) begin
         if (diff < 0) begin
            res = '0;
         end else if (diff > 14'sd255) begin
            res = 10'd255;
         end else begin
            res = diff[OUT_BITS-1:0];
         end
      end else begin
         if (dbl < 0) begin
            res = '0;
         end else if (dbl > 15'sd1023) begin
            res = 10'd1023;
         end else begin
            res = dbl[OUT_BITS-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/rgbir_quad_ir_subtract_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbir_quad_ir_subtract_core : RGB-IR 2x2 quad IR subtraction
// The odd-row red sample is registered in stage 1 and its result then in the
// result register. Throughput: one sample per cycle unless results stall; the
// line store is read once (registered) and written at most once per sample.
// Reset clears configuration, position counters, held samples and valids;
// the line store is not cleared.
// ----------------------------------------------------------------------------
module rgbir_quad_ir_subtract_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  rgbq_pkg::req_payload_type                 req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output rgbq_pkg::rsp_payload_type                 rsp_data,
   input  logic                                      csr_we,
   input  logic [rgbq_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [rgbq_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import rgbq_pkg::*;

   localparam int QUADS  = MAX_WIDTH / 2;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ADDR_W = (QUADS > 1) ? $clog2(QUADS) : 1;
   localparam int MW_W   = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = ((MW_W > GEOM_BITS) ? MW_W : GEOM_BITS) + 1;
   localparam logic [CMP_W-1:0] MAX_WIDTH_C = CMP_W'(MAX_WIDTH);

   // configuration
   logic [GEOM_BITS-1:0] line_width_ff, frame_rows_ff;
   logic                 out_mode_ff;
   logic [GAIN_BITS-1:0] gain_b_ff, gain_g_ff, gain_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         frame_rows_ff <= FRAME_ROWS_RESET;
         out_mode_ff   <= MODE_10BIT;
         gain_b_ff     <= GAIN_RESET;
         gain_g_ff     <= GAIN_RESET;
         gain_r_ff     <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_LINE_WIDTH: line_width_ff <= csr_wdata[GEOM_BITS-1:0];
            REG_FRAME_ROWS: frame_rows_ff <= csr_wdata[GEOM_BITS-1:0];
            REG_OUT_MODE:   out_mode_ff   <= csr_wdata[0];
            REG_GAIN_B:     gain_b_ff     <= csr_wdata[GAIN_BITS-1:0];
            REG_GAIN_G:     gain_g_ff     <= csr_wdata[GAIN_BITS-1:0];
            REG_GAIN_R:     gain_r_ff     <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, rsp_valid_ff;
   logic advance_out, accept;

   assign advance_out = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance_out;
   assign accept      = req_valid && !req_stall;

   // position tracking
   logic [COL_W-1:0]     col_ff, col_in, col;
   logic [GEOM_BITS-1:0] row_ff, row_in, row;
   logic [SAMPLE_BITS-1:0] held_blue_ff, held_blue_in, held_ir_ff, held_ir_in;
   logic [CMP_W-1:0]     eff_width, col_p1, col_p2;
   logic [GEOM_BITS:0]   row_p1, row_p2;
   logic [ADDR_W-1:0]    quad_addr;
   logic                 store_we, emit, done;
   logic [31:0]          quad_col_w, quad_row_w;

   always_comb begin
      col = req_data.frame_start ? '0 : col_ff;
      row = req_data.frame_start ? '0 : row_ff;
      eff_width = ({1'b0, line_width_ff} > MAX_WIDTH_C) ? MAX_WIDTH_C
                                                        : CMP_W'(line_width_ff);
      col_p1 = CMP_W'(col) + CMP_W'(1);
      col_p2 = CMP_W'(col) + CMP_W'(2);
      row_p1 = {1'b0, row} + 1'b1;
      row_p2 = {1'b0, row} + 2'd2;
      quad_addr  = ADDR_W'(col >> 1);
      quad_col_w = 32'(col >> 1);
      quad_row_w = 32'(row >> 1);

      held_blue_in = held_blue_ff;
      held_ir_in   = held_ir_ff;
      store_we     = 1'b0;
      emit         = 1'b0;
      if (!row[0]) begin
         if (!col[0]) held_blue_in = req_data.raw_sample;
         else         store_we     = 1'b1;
      end else begin
         if (!col[0]) held_ir_in = req_data.raw_sample;
         else         emit       = 1'b1;
      end
      done = (col_p2 >= eff_width) && (row_p2 >= {1'b0, frame_rows_ff});

      if (col_p1 >= eff_width) begin
         col_in = '0;
         row_in = (row_p1 >= {1'b0, frame_rows_ff}) ? '0 : row_p1[GEOM_BITS-1:0];
      end else begin
         col_in = col_p1[COL_W-1:0];
         row_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         held_blue_ff <= '0;
         held_ir_ff   <= '0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_blue_ff <= held_blue_in;
         held_ir_ff   <= held_ir_in;
      end
   end

   // even-line store of B,G pairs
   logic [PAIR_BITS-1:0] line_mem [QUADS];
   logic [PAIR_BITS-1:0] pair_rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (store_we) line_mem[quad_addr] <= {held_blue_ff, req_data.raw_sample};
         pair_rd_ff <= line_mem[quad_addr];
      end
   end

   // stage 1: item waiting on the store read
   logic                   s1_emit_ff, s1_done_ff;
   logic [SAMPLE_BITS-1:0] s1_red_ff, s1_ir_ff;
   logic [OUT_BITS-1:0]    s1_qcol_ff, s1_qrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance_out) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit;
         s1_done_ff <= done;
         s1_red_ff  <= req_data.raw_sample;
         s1_ir_ff   <= held_ir_ff;
         s1_qcol_ff <= quad_col_w[OUT_BITS-1:0];
         s1_qrow_ff <= quad_row_w[OUT_BITS-1:0];
      end
   end

   // stage 2: correction and result register
   logic [SAMPLE_BITS-1:0] ir_sub;
   rsp_payload_type        rsp_in, rsp_data_ff;

   always_comb begin
      ir_sub            = ir_for_subtract(s1_ir_ff, out_mode_ff);
      rsp_in.blue_out   = correct_colour(pair_rd_ff[PAIR_BITS-1:SAMPLE_BITS], gain_b_ff,
                                         ir_sub, out_mode_ff);
      rsp_in.green_out  = correct_colour(pair_rd_ff[SAMPLE_BITS-1:0], gain_g_ff,
                                         ir_sub, out_mode_ff);
      rsp_in.red_out    = correct_colour(s1_red_ff, gain_r_ff, ir_sub, out_mode_ff);
      rsp_in.ir_out     = ir_report(s1_ir_ff, out_mode_ff);
      rsp_in.quad_col   = s1_qcol_ff;
      rsp_in.quad_row   = s1_qrow_ff;
      rsp_in.frame_done = s1_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance_out) begin
         rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   // hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (advance_out && s1_valid_ff && s1_emit_ff) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/rgbir_quad_ir_subtract_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbir_quad_ir_subtract_checker : quad prediction and result comparison
// Watches the sample, result and register ports of the IR subtraction core.
// Mirrors its registers, line store and raster position. Predicts every 2x2
// quad result and compares each result transfer, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module rgbir_quad_ir_subtract_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  rgbq_pkg::req_payload_type           req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  rgbq_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_we,
   input  logic [rgbq_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rgbq_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  quads_outstanding,
   output int                                  mismatch_count
);
   import rgbq_pkg::*;

   localparam int QUAD_SLOTS = 1024;
   localparam int WIDTH_CAP  = 2048;

   logic [GEOM_BITS-1:0]   line_width;
   logic [GEOM_BITS-1:0]   frame_rows;
   logic                   out_mode;
   logic [GAIN_BITS-1:0]   gain_b;
   logic [GAIN_BITS-1:0]   gain_g;
   logic [GAIN_BITS-1:0]   gain_r;

   logic [SAMPLE_BITS-1:0] even_blue  [QUAD_SLOTS];
   logic [SAMPLE_BITS-1:0] even_green [QUAD_SLOTS];
   logic [SAMPLE_BITS-1:0] held_blue;
   logic [SAMPLE_BITS-1:0] held_ir;
   int unsigned            col_pos;
   int unsigned            row_pos;

   rsp_payload_type        expected_quads[$];

   initial begin
      quads_outstanding = 0;
      mismatch_count    = 0;
   end

   function automatic logic [OUT_BITS-1:0] clamp_to(input int v, input int top);
      logic [OUT_BITS-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > top) begin
         r = top[OUT_BITS-1:0];
      end else begin
         r = v[OUT_BITS-1:0];
      end
      return r;
   endfunction

   // colour less floor(gain * ir / 256), doubled in 10-bit mode and clipped per mode; ir arrives already clipped
   function automatic logic [OUT_BITS-1:0] subtract_ir(
      input logic [SAMPLE_BITS-1:0] colour,
      input logic [GAIN_BITS-1:0]   gain,
      input logic [SAMPLE_BITS-1:0] ir
   );
      int diff;
      diff = int'(colour) - ((int'(gain) * int'(ir)) >>> 8);
      if (out_mode == MODE_8BIT) begin
         return clamp_to(diff, 255);
      end
      return clamp_to(2 * diff, 1023);
   endfunction

   function automatic void advance_mosaic(input req_payload_type item);
      int unsigned            eff_w;
      int unsigned            q;
      logic [SAMPLE_BITS-1:0] ir;
      rsp_payload_type        quad;
      eff_w = (line_width > WIDTH_CAP) ? WIDTH_CAP : line_width;
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      q = (col_pos >> 1) % QUAD_SLOTS;
      if (!row_pos[0]) begin
         if (!col_pos[0]) begin
            held_blue = item.raw_sample;
         end else begin
            even_blue[q]  = held_blue;
            even_green[q] = item.raw_sample;
         end
      end else if (!col_pos[0]) begin
         held_ir = item.raw_sample;
      end else begin
         ir = held_ir;
         if (out_mode == MODE_8BIT && ir > 255) begin
            ir = 255;
         end
         quad.blue_out   = subtract_ir(even_blue[q], gain_b, ir);
         quad.green_out  = subtract_ir(even_green[q], gain_g, ir);
         quad.red_out    = subtract_ir(item.raw_sample, gain_r, ir);
         quad.ir_out     = (out_mode == MODE_8BIT) ? ir : clamp_to(2 * int'(ir), 1023);
         quad.quad_col   = OUT_BITS'(col_pos >> 1);
         quad.quad_row   = OUT_BITS'(row_pos >> 1);
         quad.frame_done = (col_pos + 2 >= eff_w) && (row_pos + 2 >= frame_rows);
         expected_quads.push_back(quad);
      end
      // wrap with greater-or-equal so a shrunk geometry recovers at once
      if (col_pos + 1 >= eff_w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= frame_rows) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic int field_differs(
      input string       name,
      input int unsigned want,
      input int unsigned got
   );
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         line_width = LINE_WIDTH_RESET;
         frame_rows = FRAME_ROWS_RESET;
         out_mode   = MODE_10BIT;
         gain_b     = GAIN_RESET;
         gain_g     = GAIN_RESET;
         gain_r     = GAIN_RESET;
         held_blue  = '0;
         held_ir    = '0;
         col_pos    = 0;
         row_pos    = 0;
         expected_quads.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LINE_WIDTH: line_width = csr_wdata[GEOM_BITS-1:0];
               REG_FRAME_ROWS: frame_rows = csr_wdata[GEOM_BITS-1:0];
               REG_OUT_MODE:   out_mode   = csr_wdata[0];
               REG_GAIN_B:     gain_b     = csr_wdata[GAIN_BITS-1:0];
               REG_GAIN_G:     gain_g     = csr_wdata[GAIN_BITS-1:0];
               REG_GAIN_R:     gain_r     = csr_wdata[GAIN_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_quads.size() == 0) begin
               $error("result transfer with no quad expected");
               errs = 1;
            end else begin
               want = expected_quads.pop_front();
               errs += field_differs("blue_out", want.blue_out, rsp_data.blue_out);
               errs += field_differs("green_out", want.green_out, rsp_data.green_out);
               errs += field_differs("red_out", want.red_out, rsp_data.red_out);
               errs += field_differs("ir_out", want.ir_out, rsp_data.ir_out);
               errs += field_differs("quad_col", want.quad_col, rsp_data.quad_col);
               errs += field_differs("quad_row", want.quad_row, rsp_data.quad_row);
               errs += field_differs("frame_done", want.frame_done, rsp_data.frame_done);
            end
         end
         if (req_valid && !req_stall) begin
            advance_mosaic(req_data);
         end
      end
      mismatch_count    <= mismatch_count + errs;
      quads_outstanding <= expected_quads.size();
   end

endmodule

// ===== tb/sv/rgbir_quad_ir_subtract_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbir_quad_ir_subtract_core_tb : IR subtraction core testbench
// Fills every line-store slot that later geometries reach with one even
// line, runs a short set of edge samples, then frames under many geometries,
// gains and both output modes, with random gaps and result stalls. A separate
// checker predicts every quad; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module rgbir_quad_ir_subtract_core_tb;
   import rgbq_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] EDGE_SAMPLES [16] = '{
      10'd1023, 10'd0,    10'd0,   10'd1023, 10'd512, 10'd511, 10'd1,   10'd255,
      10'd1023, 10'd1023, 10'd0,   10'd0,    10'd255, 10'd256, 10'd256, 10'd1020
   };

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int                       quads_outstanding;
   int                       mismatch_count;
   bit                       calm      = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rgbir_quad_ir_subtract_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rgbir_quad_ir_subtract_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .quads_outstanding (quads_outstanding),
      .mismatch_count    (mismatch_count)
   );

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 12);
   end

   task automatic push_sample(input logic [SAMPLE_BITS-1:0] sample, input logic start);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{raw_sample: sample, frame_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off until every quad is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (quads_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic load_setting(
      input int unsigned w,
      input int unsigned rows,
      input int unsigned mode,
      input int unsigned gb,
      input int unsigned gg,
      input int unsigned gr
   );
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_FRAME_ROWS, rows);
      write_reg(REG_OUT_MODE, mode);
      write_reg(REG_GAIN_B, gb);
      write_reg(REG_GAIN_G, gg);
      write_reg(REG_GAIN_R, gr);
      csr_we <= 1'b0;
   endtask

   // raster frames with random content; a few stray frame starts break lines
   task automatic run_phase(
      input int unsigned w,
      input int unsigned rows,
      input int unsigned mode,
      input int unsigned gb,
      input int unsigned gg,
      input int unsigned gr,
      input int          n_items
   );
      int unsigned span;
      int unsigned pos;
      bit          start;
      wait_idle();
      load_setting(w, rows, mode, gb, gg, gr);
      span = (w > 2048 ? 2048 : w) * rows;
      if (span < 1) begin
         span = 1;
      end
      // sometimes carry on mid-frame under the new geometry
      pos = ($urandom_range(3) == 0) ? 1 : 0;
      repeat (n_items) begin
         start = (pos == 0) || ($urandom_range(99) < 3);
         push_sample($urandom_range(1023), start);
         pos = start ? 1 : pos + 1;
         if (pos >= span) begin
            pos = 0;
         end
      end
   endtask

   initial begin
      int unsigned w;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one even line writes every line-store slot that later widths reach
      load_setting(320, 2, MODE_10BIT, 0, 1023, GAIN_RESET);
      for (int i = 0; i < 320; i++) begin
         push_sample($urandom_range(1023), i == 0);
      end
      wait_idle();

      load_setting(8, 4, MODE_8BIT, 1023, 0, 512);
      for (int i = 0; i < 16; i++) begin
         push_sample(EDGE_SAMPLES[i], i == 0);
      end
      for (int i = 0; i < 8; i++) begin
         push_sample($urandom_range(1023), i == 3);
      end

      run_phase(2, 2, MODE_10BIT, 1023, 1023, 1023, 60);
      run_phase(0, 0, MODE_8BIT, 0, 0, 0, 40);
      run_phase(1, 3, MODE_10BIT, 256, 256, 256, 40);
      run_phase(3, 1, MODE_8BIT, 512, 128, 64, 60);
      run_phase(7, 5, MODE_10BIT, 100, 700, 300, 100);
      run_phase(6, 4095, MODE_8BIT, 0, 0, 0, 80);
      run_phase(5, 3, MODE_10BIT, 1023, 0, 1023, 80);

      for (int k = 0; k < 11; k++) begin
         calm = (k == 4);
         w = ($urandom_range(9) == 0) ? $urandom_range(2, 300) : $urandom_range(2, 24);
         run_phase(w, $urandom_range(1, 10), $urandom_range(1), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023), (k == 4) ? 150 : 30);
      end
      calm = 1'b0;

      wait_idle();
      if (mismatch_count == 0) begin
         $display("rgbir_quad_ir_subtract_core verification clean");
      end else begin
         $display("rgbir_quad_ir_subtract_core verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("rgbir_quad_ir_subtract_core verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rgbq_pkg.sv
rtl/rgbir_quad_ir_subtract_core.sv
tb/sv/rgbir_quad_ir_subtract_checker.sv
tb/sv/rgbir_quad_ir_subtract_core_tb.sv
